[hw/rtl/urs_pkg.sv]
// Shared types and constants for the ultrasonic ranging sequencer.
// Request and report payload structs, opcodes, register indexes and the
// controller/datapath command and status bundles. No dependencies.
`default_nettype none

package urs_pkg;

	localparam int CHAN_W        = 3;
	localparam int DIST_W        = 16;
	localparam int STAMP_W       = 32;
	localparam int TPM_W         = 16;
	localparam int HSS_W         = 10;
	localparam int PROD_W        = STAMP_W + HSS_W;
	localparam int CHANNEL_SLOTS = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	// Channel step: (channel + 2) mod 5
	localparam logic [CHAN_W:0] CHAN_STEP = 4'd2;
	localparam logic [CHAN_W:0] CHAN_MOD  = 4'd5;

	localparam logic [DIST_W-1:0] DIST_CEIL  = 16'hFFFF;
	localparam logic [TPM_W-1:0]  TPM_RESET  = 16'd1000;
	localparam logic [HSS_W-1:0]  HSS_RESET  = 10'd170;
	localparam logic [CHAN_W:0]   SLOTS_VAL  = 4'(CHANNEL_SLOTS);

	// Opcodes
	localparam logic [1:0] OP_SCAN = 2'd0;
	localparam logic [1:0] OP_ECHO = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_SOUND_SPEED = 2'd1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic               echo_level;
		logic [STAMP_W-1:0] edge_time;
	} urs_req_t;

	typedef struct packed {
		logic              report_valid;
		logic [CHAN_W-1:0] report_channel;
		logic [DIST_W-1:0] report_distance;
		logic [CHAN_W-1:0] mux_channel;
		logic              trigger_level;
	} urs_rpt_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // latch the accepted request
		logic exec;      // update state for the opcode
		logic chk;       // saturation check, divider set-up
		logic div_step;  // one restoring division step
		logic publish;   // compare with stored value, toggle lsb, store
		logic ld_out;    // load the report register
	} urs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] opcode;
		logic       echo_level;
		logic       pending;
		logic       sat;
	} urs_sts_t;

	function automatic logic [CHAN_W-1:0] next_chan(input logic [CHAN_W-1:0] c);
		logic [CHAN_W:0] s;
		s = {1'b0, c} + CHAN_STEP;
		if (s >= CHAN_MOD) begin
			s = s - CHAN_MOD;
		end
		return s[CHAN_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/urs_ctrl.sv]
// Controller state machine for the ultrasonic ranging sequencer.
// Sequences request intake, execution, division, publish and report
// hand-off. Depends on urs_pkg.
`default_nettype none

module urs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	output logic                   res_valid,
	input  wire logic              res_stall,
	input  wire urs_pkg::urs_sts_t sts,
	output urs_pkg::urs_cmd_t      ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PUB  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [3:0] cnt_q;
	logic       res_valid_q;
	logic       out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				priority if (sts.opcode == urs_pkg::OP_SCAN && sts.pending) begin
					state_d = ST_PUB;
				end else if (sts.opcode == urs_pkg::OP_ECHO && !sts.echo_level) begin
					state_d = ST_CHK;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_CHK: begin
				ctl.chk = 1'b1;
				state_d = sts.sat ? ST_PUB : ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == 4'hF) begin
					state_d = ST_PUB;
				end
			end
			ST_PUB: begin
				ctl.publish = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctl.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, division step count, report valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.chk) begin
				cnt_q <= '0;
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (ctl.ld_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/urs_dp.sv]
// Datapath for the ultrasonic ranging sequencer: channel and echo state,
// configuration registers, multiplier, serial divider, stored distances and
// the report register. Depends on urs_pkg.
`default_nettype none

module urs_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire urs_pkg::urs_req_t                  cmd,
	input  wire logic                               cfg_we,
	input  wire logic [urs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [urs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire urs_pkg::urs_cmd_t                  ctl,
	output urs_pkg::urs_sts_t                       sts,
	output urs_pkg::urs_rpt_t                       res
);

	// Architectural state
	logic [urs_pkg::TPM_W-1:0]   tpm_q;
	logic [urs_pkg::HSS_W-1:0]   hss_q;
	logic [urs_pkg::CHAN_W-1:0]  active_q;
	logic                        pending_q;
	logic                        trigger_q;
	logic [urs_pkg::STAMP_W-1:0] last_stamp_q;
	logic [urs_pkg::DIST_W-1:0]  stored_q [urs_pkg::CHANNEL_SLOTS];

	// Working registers
	urs_pkg::urs_req_t           item_q;
	logic [urs_pkg::PROD_W-1:0]  prod_q;
	logic [urs_pkg::DIST_W-1:0]  rem_q;
	logic [urs_pkg::DIST_W-1:0]  lo_q;
	logic                        rep_valid_q;
	logic [urs_pkg::CHAN_W-1:0]  rep_chan_q;
	logic [urs_pkg::DIST_W-1:0]  rep_dist_q;
	urs_pkg::urs_rpt_t           out_q;

	logic [urs_pkg::STAMP_W-1:0] interval;
	logic [urs_pkg::DIST_W:0]    trial;
	logic                        trial_ge;
	logic                        slot_ok;
	logic [urs_pkg::DIST_W-1:0]  pub_dist;

	assign interval = item_q.edge_time - last_stamp_q;

	// Product above the 16-bit quotient range (or zero divisor) saturates
	assign sts.sat = prod_q[urs_pkg::PROD_W-1:urs_pkg::DIST_W] >=
		{{(urs_pkg::PROD_W-urs_pkg::DIST_W-urs_pkg::TPM_W){1'b0}}, tpm_q};
	assign sts.opcode     = item_q.opcode;
	assign sts.echo_level = item_q.echo_level;
	assign sts.pending    = pending_q;

	// Restoring division step: bring down one dividend bit
	assign trial    = {rem_q, lo_q[urs_pkg::DIST_W-1]};
	assign trial_ge = trial >= {1'b0, tpm_q};

	// Equal reports get the lsb flipped
	assign slot_ok  = {1'b0, rep_chan_q} < urs_pkg::SLOTS_VAL;
	assign pub_dist = (rep_dist_q == stored_q[rep_chan_q]) ? (rep_dist_q ^ 16'h0001)
		: rep_dist_q;

	assign res = out_q;

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q        <= urs_pkg::TPM_RESET;
			hss_q        <= urs_pkg::HSS_RESET;
			active_q     <= '0;
			pending_q    <= 1'b0;
			trigger_q    <= 1'b0;
			last_stamp_q <= '0;
			for (int i = 0; i < urs_pkg::CHANNEL_SLOTS; i++) begin
				stored_q[i] <= urs_pkg::DIST_CEIL;
			end
		end else begin
			if (cfg_we && cfg_index == urs_pkg::CFG_TICKS_PER_MS) begin
				tpm_q <= cfg_data[urs_pkg::TPM_W-1:0];
			end
			if (cfg_we && cfg_index == urs_pkg::CFG_HALF_SOUND_SPEED) begin
				hss_q <= cfg_data[urs_pkg::HSS_W-1:0];
			end
			if (ctl.exec) begin
				unique case (item_q.opcode)
					urs_pkg::OP_SCAN: begin
						pending_q <= 1'b1;
						active_q  <= urs_pkg::next_chan(active_q);
						trigger_q <= 1'b1;
					end
					urs_pkg::OP_ECHO: begin
						last_stamp_q <= item_q.edge_time;
						pending_q    <= item_q.echo_level;
					end
					urs_pkg::OP_TICK: begin
						trigger_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.publish && slot_ok) begin
				stored_q[rep_chan_q] <= pub_dist;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		if (ctl.exec) begin
			prod_q <= {{urs_pkg::HSS_W{1'b0}}, interval} *
				{{urs_pkg::STAMP_W{1'b0}}, hss_q};
			if (item_q.opcode == urs_pkg::OP_SCAN) begin
				rep_valid_q <= pending_q;
				rep_chan_q  <= pending_q ? active_q : '0;
				rep_dist_q  <= pending_q ? urs_pkg::DIST_CEIL : '0;
			end else if (item_q.opcode == urs_pkg::OP_ECHO && !item_q.echo_level) begin
				rep_valid_q <= 1'b1;
				rep_chan_q  <= active_q;
				rep_dist_q  <= '0;
			end else begin
				rep_valid_q <= 1'b0;
				rep_chan_q  <= '0;
				rep_dist_q  <= '0;
			end
		end
		if (ctl.chk) begin
			rem_q      <= prod_q[urs_pkg::DIST_W +: urs_pkg::DIST_W];
			lo_q       <= prod_q[urs_pkg::DIST_W-1:0];
			rep_dist_q <= urs_pkg::DIST_CEIL;
		end
		if (ctl.div_step) begin
			rem_q      <= trial_ge ? 16'(trial - {1'b0, tpm_q}) : trial[urs_pkg::DIST_W-1:0];
			lo_q       <= {lo_q[urs_pkg::DIST_W-2:0], 1'b0};
			rep_dist_q <= {rep_dist_q[urs_pkg::DIST_W-2:0], trial_ge};
		end
		if (ctl.publish && slot_ok) begin
			rep_dist_q <= pub_dist;
		end
		if (ctl.ld_out) begin
			out_q.report_valid    <= rep_valid_q;
			out_q.report_channel  <= rep_chan_q;
			out_q.report_distance <= rep_dist_q;
			out_q.mux_channel     <= active_q;
			out_q.trigger_level   <= trigger_q;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ultrasonic_ranging_sequencer.sv]
// Ultrasonic ranging sequencer top level: controller plus datapath.
// Depends on urs_pkg, urs_ctrl and urs_dp.
//
// Use: requests (cmd) carry an opcode: scan start, echo edge with level and
// timer stamp, or millisecond tick. Each request yields exactly one report
// (res) holding any distance/timeout report plus mux channel and trigger.
// A request is taken when cmd_valid is high and cmd_stall low; a report is
// taken when res_valid is high and res_stall low.
// A falling echo edge passes multiply, saturation check, 16 restoring
// division steps on the ticks_per_ms divisor, publish and output load; a
// saturated distance or zero divisor skips the division steps, a scan start
// with a timeout goes from execute straight to publish, and other requests
// go from execute to output load. One request is in work at a time: the
// next is not taken until the report register is loaded.
// The report register holds a finished report while the next request is
// accepted; a stalled receiver holds the report and the work finishes in
// its last stage until the register frees.
// Reset clears the channel, echo and trigger state, restores the register
// defaults (1000 ticks/ms, 170 m/s) and sets every stored distance to
// 65535. Configuration writes (cfg) are always ready; write only when idle.
`default_nettype none

module ultrasonic_ranging_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire urs_pkg::urs_req_t              cmd,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output urs_pkg::urs_rpt_t                   res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [urs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [urs_pkg::CFG_DATA_W-1:0] cfg_data
);

	urs_pkg::urs_cmd_t ctl;
	urs_pkg::urs_sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencing
	urs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Arithmetic and state
	urs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res       (res)
	);

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for ultrasonic_ranging_sequencer.
// Holds a scoreboard class that predicts each report; depends on urs_pkg and the RTL.
// Directed requests first, then random scan/echo sequences under several register settings.

import urs_pkg::*;

// Predicts the report for each accepted request and checks the reports in order
class range_scoreboard;
	logic [TPM_W-1:0]   ticks_cfg;
	logic [HSS_W-1:0]   speed_cfg;
	logic [CHAN_W-1:0]  chan;
	logic               echo_open;
	logic               trig;
	logic [STAMP_W-1:0] last_stamp;
	logic [DIST_W-1:0]  stored_mm [CHANNEL_SLOTS];
	urs_rpt_t           expected [$];
	int                 mismatches;

	function new();
		ticks_cfg  = TPM_RESET;
		speed_cfg  = HSS_RESET;
		chan       = '0;
		echo_open  = 1'b0;
		trig       = 1'b0;
		last_stamp = '0;
		mismatches = 0;
		foreach (stored_mm[i]) stored_mm[i] = DIST_CEIL;
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == CFG_TICKS_PER_MS) begin
			ticks_cfg = val[TPM_W-1:0];
		end else if (idx == CFG_HALF_SOUND_SPEED) begin
			speed_cfg = val[HSS_W-1:0];
		end
	endfunction

	// Same value as last time on this channel: flip the lsb so it shows as a change
	function logic [DIST_W-1:0] settle(logic [CHAN_W-1:0] c, logic [DIST_W-1:0] mm);
		logic [DIST_W-1:0] v;
		v = mm;
		if (int'(c) < CHANNEL_SLOTS) begin
			if (v == stored_mm[c]) v[0] = ~v[0];
			stored_mm[c] = v;
		end
		return v;
	endfunction

	function void note_request(urs_req_t q);
		urs_rpt_t           e;
		logic [STAMP_W-1:0] span;
		logic [63:0]        mm;
		e = '0;
		case (q.opcode)
			OP_SCAN: begin
				// previous echo never ended: timeout for the old channel
				if (echo_open) begin
					e.report_valid    = 1'b1;
					e.report_channel  = chan;
					e.report_distance = settle(chan, DIST_CEIL);
				end
				echo_open = 1'b1;
				chan      = CHAN_W'((int'(chan) + 2) % 5);
				trig      = 1'b1;
			end
			OP_ECHO: begin
				span       = q.edge_time - last_stamp;
				last_stamp = q.edge_time;
				if (!q.echo_level) begin
					if (ticks_cfg == 0) begin
						mm = 64'(DIST_CEIL);
					end else begin
						mm = (64'(span) * 64'(speed_cfg)) / 64'(ticks_cfg);
						if (mm > 64'(DIST_CEIL)) mm = 64'(DIST_CEIL);
					end
					e.report_valid    = 1'b1;
					e.report_channel  = chan;
					e.report_distance = settle(chan, mm[DIST_W-1:0]);
				end
				echo_open = q.echo_level;
			end
			OP_TICK: begin
				trig = 1'b0;
			end
			default: begin
			end
		endcase
		e.mux_channel   = chan;
		e.trigger_level = trig;
		expected.push_back(e);
	endfunction

	function void compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		end
	endfunction

	function void check_report(urs_rpt_t got);
		urs_rpt_t want;
		if (expected.size() == 0) begin
			mismatches++;
			$display("%0t: report expected none actual %h", $time, got);
			return;
		end
		want = expected.pop_front();
		compare_field("report_valid", want.report_valid, got.report_valid);
		compare_field("report_channel", want.report_channel, got.report_channel);
		compare_field("report_distance", want.report_distance, got.report_distance);
		compare_field("mux_channel", want.mux_channel, got.mux_channel);
		compare_field("trigger_level", want.trigger_level, got.trigger_level);
	endfunction

	function int outstanding();
		return expected.size();
	endfunction
endclass

module testbench;
	// Opcode and register indexes the package leaves unnamed
	localparam logic [1:0]           OP_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	urs_req_t              cmd       = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	urs_rpt_t              res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	range_scoreboard sb;
	int              sent      = 0;
	int              hold_left = 0;
	int              rx_pick;
	bit              tx_calm   = 1'b0;
	bit              rx_calm   = 1'b0;
	logic [31:0]     timer_now;
	logic [31:0]     fav_span;

	ultrasonic_ranging_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Report side: check taken reports, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			sb.check_report(res);
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!arst_n || rx_calm) begin
			res_stall <= 1'b0;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 65) begin
				res_stall <= 1'b0;
			end else if (rx_pick < 95) begin
				hold_left = $urandom_range(0, 3);
				res_stall <= 1'b1;
			end else begin
				hold_left = $urandom_range(15, 60);
				res_stall <= 1'b1;
			end
		end
	end

	function automatic urs_req_t mk(logic [1:0] op, logic lvl, logic [31:0] stamp);
		urs_req_t q;
		q.opcode     = op;
		q.echo_level = lvl;
		q.edge_time  = stamp;
		return q;
	endfunction

	function automatic urs_req_t rand_req();
		return mk(2'($urandom), 1'($urandom),
			$urandom_range(0, 1) ? 32'($urandom) : timer_now + 32'($urandom_range(0, 4000)));
	endfunction

	// Echo interval aimed at the whole distance range, with some repeats and wild values
	function automatic logic [31:0] pick_span();
		logic [63:0] wide;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 15) return fav_span;
		if (r < 25 || sb.ticks_cfg == 0 || sb.speed_cfg == 0) return 32'($urandom);
		wide = 64'($urandom_range(0, 70000)) * 64'(sb.ticks_cfg) / 64'(sb.speed_cfg);
		wide = wide + 64'($urandom_range(0, 3));
		if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
		return wide[31:0];
	endfunction

	// Present one request after a random gap; valid stays high afterwards
	task automatic send_req(input urs_req_t q);
		int gap;
		int r;
		gap = 0;
		if (!tx_calm) begin
			r = $urandom_range(0, 99);
			if (r >= 92) gap = $urandom_range(8, 40);
			else if (r >= 55) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			cmd       <= rand_req();
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= q;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_request(q);
		sent++;
	endtask

	// Register write; valid is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] tpm, input logic [CFG_DATA_W-1:0] hss,
			input bit spare);
		write_reg(CFG_TICKS_PER_MS, tpm);
		write_reg(CFG_HALF_SOUND_SPEED, hss);
		if (spare) begin
			// writes to unused indexes must change nothing
			write_reg(CFG_SPARE_A, 16'($urandom));
			write_reg(CFG_SPARE_B, 16'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One scan sequence, mostly well formed, sometimes a stray request
	task automatic ranging_burst();
		logic [31:0] rise_at;
		logic [31:0] span;
		tx_calm = ($urandom_range(0, 7) == 0);
		rx_calm = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 99) < 72) begin
			rise_at = timer_now + 32'($urandom_range(1, 5000));
			span    = pick_span();
			send_req(mk(OP_SCAN, 1'($urandom), 32'($urandom)));
			if ($urandom_range(0, 4) != 0) send_req(mk(OP_TICK, 1'($urandom), 32'($urandom)));
			if ($urandom_range(0, 9) != 0) begin
				send_req(mk(OP_ECHO, 1'b1, rise_at));
				// a missing falling edge leaves a timeout for the next scan
				if ($urandom_range(0, 7) != 0) send_req(mk(OP_ECHO, 1'b0, rise_at + span));
			end
			timer_now = rise_at + span + 32'($urandom_range(0, 1000));
		end else begin
			send_req(rand_req());
		end
	endtask

	// Random requests under one register setting, then drain
	task automatic run_phase(input int quota);
		int stop_at;
		stop_at   = sent + quota;
		timer_now = $urandom;
		fav_span  = pick_span();
		while (sent < stop_at) ranging_burst();
		cmd_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Directed requests from reset defaults
	task automatic directed_run();
		int i;
		send_req(mk(OP_TICK, 1'b1, 32'hFFFF_FFFF));
		send_req(mk(OP_UNUSED, 1'b1, 32'h1234_5678));
		// falling edge with no rising edge before it, zero interval
		send_req(mk(OP_ECHO, 1'b0, 32'h0000_0000));
		send_req(mk(OP_SCAN, 1'b0, 32'h0000_0000));
		// echo never ended: timeout, stored 65535 so the lsb flips
		send_req(mk(OP_SCAN, 1'b1, 32'hFFFF_FFFF));
		send_req(mk(OP_TICK, 1'b0, 32'h0000_0000));
		// timer wraps between the edges
		send_req(mk(OP_ECHO, 1'b1, 32'hFFFF_FFF0));
		send_req(mk(OP_ECHO, 1'b0, 32'h0000_0010));
		// longest interval saturates
		send_req(mk(OP_ECHO, 1'b1, 32'h0000_0000));
		send_req(mk(OP_ECHO, 1'b0, 32'hFFFF_FFFF));
		send_req(mk(OP_ECHO, 1'b1, 32'hFFFF_FFFF));
		send_req(mk(OP_ECHO, 1'b0, 32'h0000_0000));
		// a repeated rising edge restarts the interval
		send_req(mk(OP_ECHO, 1'b1, 32'h0001_0000));
		send_req(mk(OP_ECHO, 1'b1, 32'h0001_1000));
		send_req(mk(OP_ECHO, 1'b0, 32'h0001_13E8));
		// five scans return to the same channel, with repeated timeouts
		for (i = 0; i < 5; i++) send_req(mk(OP_SCAN, 1'($urandom), 32'($urandom)));
		// same distance as stored on this channel: lsb flips
		send_req(mk(OP_ECHO, 1'b1, 32'h8000_0000));
		send_req(mk(OP_ECHO, 1'b0, 32'h8000_03E8));
		send_req(mk(OP_UNUSED, 1'b0, 32'h0000_0000));
	endtask

	// Main sequence
	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();
		run_phase(130);

		configure(16'hFFFF, 16'd1023, 1'b0);
		run_phase(100);

		configure(16'd1, 16'd1, 1'b0);
		run_phase(100);

		// zero divisor; upper bits of the speed write are junk
		configure(16'd0, 16'($urandom), 1'b0);
		run_phase(60);

		// zero multiplier and writes to unused indexes
		configure(16'($urandom_range(1, 65535)), {6'($urandom), 10'd0}, 1'b1);
		run_phase(40);

		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 1023)), 1'b0);
		run_phase(180);

		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10000000;
		$display("testbench: FAIL");
		$finish;
	end
endmodule
